/* design/ccps_pkg.sv */
// Shared types, codes and tables for the class constant-pool scanner.
// Used by ccps_core and class_constant_pool_scanner; no dependencies.
`default_nettype none

package ccps_pkg;

    localparam int unsigned HEADER_BYTES = 10;

    localparam logic [15:0] MIN_LENGTH_RESET = 16'd3;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd49;

    localparam logic [7:0] TAG_UTF8   = 8'd1;
    localparam logic [7:0] TAG_LONG   = 8'd5;
    localparam logic [7:0] TAG_DOUBLE = 8'd6;
    localparam logic [7:0] CHAR_AT    = 8'h40;

    localparam logic [1:0] STATUS_UTF8     = 2'd0;
    localparam logic [1:0] STATUS_POOL_END = 2'd1;
    localparam logic [1:0] STATUS_BAD_TAG  = 2'd2;

    localparam logic [0:0] CFG_MIN_LENGTH = 1'b0;
    localparam logic [0:0] CFG_MAX_LENGTH = 1'b1;

    typedef struct packed {
        logic [15:0] entry_index;
        logic [15:0] string_length;
        logic        is_match;
        logic [1:0]  status;
        logic        pool_done;
    } result_t;

    // fixed body size per tag, 0 for unknown tags
    function automatic logic [3:0] body_size(input logic [7:0] tag);
        logic [3:0] n;
        n = 4'd0;
        case (tag)
            8'd3, 8'd4:                         n = 4'd4;
            8'd5, 8'd6:                         n = 4'd8;
            8'd7, 8'd8, 8'd16:                  n = 4'd2;
            8'd9, 8'd10, 8'd11, 8'd12, 8'd18:   n = 4'd4;
            8'd15:                              n = 4'd3;
            default:                            n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage

`default_nettype wire

/* design/class_constant_pool_scanner.sv */
// Top level: stream ports, config registers, input and result registers.
// Depends on ccps_pkg and ccps_core.
`default_nettype none

// Takes one class-file byte per cycle and emits one word for each finished
// UTF8 constant-pool entry, plus a single word when the pool ends on a
// non-UTF8 entry or header, or on an unknown tag. Throughput is one byte per
// clock while no result word is stalled; a byte's result word goes through
// the input register, then the result register, and a stalled result word
// holds the input until it is taken. The parser itself is one state update
// per byte between those two registers. Raise file_start on byte 0 of each file.
// Write min_length/max_length only while the block is idle.
module class_constant_pool_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] file_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [15:0] entry_index, [31:16] string_length,
                                             // [32] is_match, [39:33] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast,   // pool_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg;
    ccps_pkg::result_t out_reg;
    logic [15:0]       min_len_reg;
    logic [15:0]       max_len_reg;
    logic              process;
    logic              res_valid;
    ccps_pkg::result_t res;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= ccps_pkg::MIN_LENGTH_RESET;
            max_len_reg <= ccps_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ccps_pkg::CFG_MIN_LENGTH: min_len_reg <= cfg_data;
                ccps_pkg::CFG_MAX_LENGTH: max_len_reg <= cfg_data;
                default:                  min_len_reg <= min_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (process)
                out_valid_reg <= res_valid;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
        if (process && res_valid)
            out_reg <= res;
    end

    ccps_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (process),
        .data_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .min_length (min_len_reg),
        .max_length (max_len_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.is_match, out_reg.string_length, out_reg.entry_index};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.pool_done;

endmodule

`default_nettype wire

/* design/ccps_core.sv */
// Parse state machine and word@word tracker; one byte per step.
// Depends on ccps_pkg.
`default_nettype none

module ccps_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              file_start,
    input  wire logic [15:0]       min_length,
    input  wire logic [15:0]       max_length,
    output logic                   res_valid,
    output ccps_pkg::result_t      res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_SKIP,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TEXT,
        PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next, e_phase;
    logic [3:0]  hcount_reg, hcount_next, e_hcount;
    logic [15:0] pool_reg, pool_next, e_pool;
    logic [15:0] cur_reg, cur_next, e_cur;
    logic [3:0]  skip_reg, skip_next, e_skip;
    logic [15:0] len_reg, len_next, e_len;
    logic [15:0] left_reg, left_next, e_left;
    logic [1:0]  wrun_reg, wrun_next, e_wrun;
    logic        armed_reg, armed_next, e_armed;
    logic [1:0]  arun_reg, arun_next, e_arun;
    logic        seen_reg, seen_next, e_seen;

    logic [15:0] adv_slots;
    logic [16:0] adv_sum;
    logic        adv_done;
    logic [3:0]  tag_size;
    logic [3:0]  skip_dec;
    logic [15:0] left_dec;
    logic        utf_finish;
    logic        len_ok;

    // file_start restarts parsing on this very byte
    always_comb
    begin
        e_phase  = file_start ? PH_HEADER : phase_reg;
        e_hcount = file_start ? 4'd0  : hcount_reg;
        e_pool   = file_start ? 16'd0 : pool_reg;
        e_cur    = file_start ? 16'd1 : cur_reg;
        e_skip   = file_start ? 4'd0  : skip_reg;
        e_len    = file_start ? 16'd0 : len_reg;
        e_left   = file_start ? 16'd0 : left_reg;
        e_wrun   = file_start ? 2'd0  : wrun_reg;
        e_armed  = file_start ? 1'b0  : armed_reg;
        e_arun   = file_start ? 2'd0  : arun_reg;
        e_seen   = file_start ? 1'b0  : seen_reg;
    end

    assign adv_slots = (e_phase == PH_SKIP) ? e_left : 16'd1;
    assign adv_sum   = {1'b0, e_cur} + {1'b0, adv_slots};
    assign adv_done  = adv_sum >= {1'b0, e_pool};
    assign tag_size  = ccps_pkg::body_size(data_byte);
    assign skip_dec  = (e_skip != 4'd0) ? e_skip - 4'd1 : 4'd0;
    assign left_dec  = e_left - 16'd1;

    always_comb
    begin
        phase_next  = e_phase;
        hcount_next = e_hcount;
        pool_next   = e_pool;
        cur_next    = e_cur;
        skip_next   = e_skip;
        len_next    = e_len;
        left_next   = e_left;
        wrun_next   = e_wrun;
        armed_next  = e_armed;
        arun_next   = e_arun;
        seen_next   = e_seen;
        utf_finish  = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        case (e_phase)
            PH_HEADER:
            begin
                if (e_hcount == 4'd8)
                    pool_next = {data_byte, 8'h00};
                else if (e_hcount == 4'd9)
                    pool_next = {e_pool[15:8], data_byte};
                hcount_next = e_hcount + 4'd1;
                if (hcount_next >= 4'(ccps_pkg::HEADER_BYTES))
                begin
                    cur_next = 16'd1;
                    if (pool_next <= 16'd1)
                    begin
                        phase_next    = PH_IDLE;
                        res_valid     = 1'b1;
                        res.status    = ccps_pkg::STATUS_POOL_END;
                        res.pool_done = 1'b1;
                    end
                    else
                        phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                if (data_byte == ccps_pkg::TAG_UTF8)
                begin
                    len_next   = 16'd0;
                    wrun_next  = 2'd0;
                    armed_next = 1'b0;
                    arun_next  = 2'd0;
                    seen_next  = 1'b0;
                    phase_next = PH_LEN_HI;
                end
                else if (tag_size == 4'd0)
                begin
                    phase_next      = PH_IDLE;
                    res_valid       = 1'b1;
                    res.entry_index = e_cur;
                    res.status      = ccps_pkg::STATUS_BAD_TAG;
                    res.pool_done   = 1'b1;
                end
                else
                begin
                    skip_next  = tag_size;
                    phase_next = PH_SKIP;
                    if (data_byte == ccps_pkg::TAG_LONG || data_byte == ccps_pkg::TAG_DOUBLE)
                    begin
                        armed_next = 1'b0;
                        left_next  = 16'd2;
                    end
                    else
                        left_next = 16'd1;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 4'd0)
                begin
                    cur_next   = adv_sum[15:0];
                    phase_next = adv_done ? PH_IDLE : PH_TAG;
                    if (adv_done)
                    begin
                        res_valid       = 1'b1;
                        res.entry_index = e_cur;
                        res.status      = ccps_pkg::STATUS_POOL_END;
                        res.pool_done   = 1'b1;
                    end
                end
            end
            PH_LEN_HI:
            begin
                len_next   = {data_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next  = {e_len[15:8], data_byte};
                left_next = len_next;
                if (len_next == 16'd0)
                    utf_finish = 1'b1;
                else
                    phase_next = PH_TEXT;
            end
            PH_TEXT:
            begin
                if (data_byte == ccps_pkg::CHAR_AT)
                begin
                    armed_next = (e_wrun == 2'd2);
                    arun_next  = 2'd0;
                    wrun_next  = 2'd0;
                end
                else if (ccps_pkg::is_word(data_byte))
                begin
                    if (e_wrun != 2'd2)
                        wrun_next = e_wrun + 2'd1;
                    if (e_armed)
                    begin
                        if (e_arun != 2'd2)
                            arun_next = e_arun + 2'd1;
                        if (arun_next == 2'd2)
                            seen_next = 1'b1;
                    end
                end
                else
                begin
                    wrun_next  = 2'd0;
                    armed_next = 1'b0;
                    arun_next  = 2'd0;
                end
                left_next = left_dec;
                if (left_dec == 16'd0)
                    utf_finish = 1'b1;
            end
            default:
            begin
                phase_next = e_phase;
            end
        endcase

        if (utf_finish)
        begin
            cur_next          = adv_sum[15:0];
            phase_next        = adv_done ? PH_IDLE : PH_TAG;
            res_valid         = 1'b1;
            res.entry_index   = e_cur;
            res.string_length = len_next;
            res.is_match      = seen_next && len_ok;
            res.status        = ccps_pkg::STATUS_UTF8;
            res.pool_done     = adv_done;
        end
    end

    assign len_ok = (len_next >= min_length) && (len_next <= max_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= 4'd0;
            pool_reg   <= 16'd0;
            cur_reg    <= 16'd1;
            skip_reg   <= 4'd0;
            len_reg    <= 16'd0;
            left_reg   <= 16'd0;
            wrun_reg   <= 2'd0;
            armed_reg  <= 1'b0;
            arun_reg   <= 2'd0;
            seen_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            pool_reg   <= pool_next;
            cur_reg    <= cur_next;
            skip_reg   <= skip_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            wrun_reg   <= wrun_next;
            armed_reg  <= armed_next;
            arun_reg   <= arun_next;
            seen_reg   <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.pool_done |=> phase_reg == PH_IDLE)
        else $error("pool end did not park the parser");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ccps_pkg::STATUS_UTF8 |->
            res.pool_done && !res.is_match && res.string_length == 16'd0)
        else $error("non-UTF8 result carries text fields");

    a_runs_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        wrun_reg != 2'd3 && arun_reg != 2'd3)
        else $error("character run counter overflowed");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE && !file_start |-> !res_valid)
        else $error("result after pool end without restart");
`endif

endmodule

`default_nettype wire
